// ===== rtl/vsd_pkg.sv =====
// Shared types, format codes and step tables for the voice sample decoder.
package vsd_pkg;

  localparam logic [1:0] FMT_U8    = 2'd0;
  localparam logic [1:0] FMT_S8    = 2'd1;
  localparam logic [1:0] FMT_W16   = 2'd2;
  localparam logic [1:0] FMT_ADPCM = 2'd3;

  localparam logic [7:0] PRED_RESET = 8'd128;
  localparam logic [5:0] STEP_MAX   = 6'd48;

  localparam logic signed [7:0] SCALE_TAB [64] = '{
    8'sd0,  8'sd1,  8'sd2,  8'sd3,  8'sd4,  8'sd5,  8'sd6,  8'sd7,
    8'sd0,  -8'sd1, -8'sd2, -8'sd3, -8'sd4, -8'sd5, -8'sd6, -8'sd7,
    8'sd1,  8'sd3,  8'sd5,  8'sd7,  8'sd9,  8'sd11, 8'sd13, 8'sd15,
    -8'sd1, -8'sd3, -8'sd5, -8'sd7, -8'sd9, -8'sd11, -8'sd13, -8'sd15,
    8'sd2,  8'sd6,  8'sd10, 8'sd14, 8'sd18, 8'sd22, 8'sd26, 8'sd30,
    -8'sd2, -8'sd6, -8'sd10, -8'sd14, -8'sd18, -8'sd22, -8'sd26, -8'sd30,
    8'sd4,  8'sd12, 8'sd20, 8'sd28, 8'sd36, 8'sd44, 8'sd52, 8'sd60,
    -8'sd4, -8'sd12, -8'sd20, -8'sd28, -8'sd36, -8'sd44, -8'sd52, -8'sd60
  };

  localparam logic signed [7:0] ADJUST_TAB [64] = '{
    8'sd0,   8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd16, 8'sd16, 8'sd16,
    8'sd0,   8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd16, 8'sd16, 8'sd16,
    -8'sd16, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd16, 8'sd16, 8'sd16,
    -8'sd16, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd16, 8'sd16, 8'sd16,
    -8'sd16, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd16, 8'sd16, 8'sd16,
    -8'sd16, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd16, 8'sd16, 8'sd16,
    -8'sd16, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0,  8'sd0,  8'sd0,
    -8'sd16, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0,  8'sd0,  8'sd0
  };

  typedef struct packed {
    logic go;      // held item is processed this cycle
    logic second;  // low nibble pass of an ADPCM byte
  } step_req_t;

  typedef struct packed {
    logic       emit;   // a sample is produced
    logic       done;   // held item is finished
    logic [7:0] sample;
    logic       last;
  } step_res_t;

endpackage

// ===== rtl/vsd_nibble.sv =====
// One ADPCM nibble: table lookup and clamped predictor and step update.
module vsd_nibble (
  input  logic [3:0] nib,
  input  logic [7:0] pred,
  input  logic [5:0] step,
  output logic [7:0] pred_next,
  output logic [5:0] step_next
);

  logic [6:0]        idx_sum;
  logic [5:0]        idx;
  logic signed [8:0] st_sum;
  logic signed [9:0] pr_sum;

  always_comb begin
    idx_sum = {3'b000, nib} + {1'b0, step};
    idx = idx_sum[6] ? 6'd63 : idx_sum[5:0];
    st_sum = $signed({3'b000, step}) + 9'(vsd_pkg::ADJUST_TAB[idx]);
    pr_sum = $signed({2'b00, pred}) + 10'(vsd_pkg::SCALE_TAB[idx]);
    if (st_sum < 0) begin
      step_next = 6'd0;
    end else if (st_sum > $signed({3'b000, vsd_pkg::STEP_MAX})) begin
      step_next = vsd_pkg::STEP_MAX;
    end else begin
      step_next = st_sum[5:0];
    end
    if (pr_sum < 0) begin
      pred_next = 8'd0;
    end else if (pr_sum > 10'sd255) begin
      pred_next = 8'd255;
    end else begin
      pred_next = pr_sum[7:0];
    end
  end

endmodule

// ===== rtl/vsd_decode.sv =====
// Decoder state and per-cycle sample generation for all four formats.
module vsd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          fmt,
  input  logic [7:0]          byte_in,
  input  logic                start,
  input  vsd_pkg::step_req_t  req,
  output vsd_pkg::step_res_t  res
);

  logic [7:0] predictor, predictor_next;
  logic [5:0] step_index, step_index_next;
  logic       header_pending, header_pending_next;
  logic       byte_phase, byte_phase_next;

  logic       hp_eff, bp_eff;
  logic [3:0] nib;
  logic [7:0] nib_pred;
  logic [5:0] nib_step;

  assign hp_eff = (start && !req.second) ? 1'b1 : header_pending;
  assign bp_eff = (start && !req.second) ? 1'b0 : byte_phase;
  assign nib    = req.second ? byte_in[3:0] : byte_in[7:4];

  vsd_nibble u_nibble (
    .nib       (nib),
    .pred      (predictor),
    .step      (step_index),
    .pred_next (nib_pred),
    .step_next (nib_step)
  );

  always_comb begin
    predictor_next      = predictor;
    step_index_next     = step_index;
    header_pending_next = hp_eff;
    byte_phase_next     = bp_eff;
    res.emit   = 1'b1;
    res.done   = 1'b1;
    res.sample = byte_in;
    res.last   = 1'b1;
    unique case (fmt)
      vsd_pkg::FMT_U8: begin
        res.sample = byte_in ^ 8'h80;
      end
      vsd_pkg::FMT_S8: begin
        res.sample = byte_in;
      end
      vsd_pkg::FMT_W16: begin
        res.emit        = bp_eff;
        byte_phase_next = !bp_eff;
      end
      vsd_pkg::FMT_ADPCM: begin
        if (hp_eff && !req.second) begin
          res.emit            = 1'b0;
          predictor_next      = byte_in;
          step_index_next     = 6'd0;
          header_pending_next = 1'b0;
        end else begin
          predictor_next  = nib_pred;
          step_index_next = nib_step;
          res.sample      = nib_pred ^ 8'h80;
          res.last        = req.second;
          res.done        = req.second;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor      <= vsd_pkg::PRED_RESET;
      step_index     <= 6'd0;
      header_pending <= 1'b1;
      byte_phase     <= 1'b0;
    end else if (req.go) begin
      predictor      <= predictor_next;
      step_index     <= step_index_next;
      header_pending <= header_pending_next;
      byte_phase     <= byte_phase_next;
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_index <= vsd_pkg::STEP_MAX)
    else $error("step index above limit");
  a_header_no_sample: assert property (@(posedge clk) disable iff (rst)
    req.go && fmt == vsd_pkg::FMT_ADPCM && hp_eff && !req.second |-> !res.emit)
    else $error("header byte produced a sample");
  a_header_loads: assert property (@(posedge clk) disable iff (rst)
    req.go && fmt == vsd_pkg::FMT_ADPCM && hp_eff && !req.second
    |=> predictor == $past(byte_in) && step_index == 6'd0 && !header_pending)
    else $error("header byte did not load predictor");
`endif

endmodule

// ===== rtl/voice_sample_decoder.sv =====
// Top level: input holding register, format register and result register.
//
//   channel | signals                                     | dir
//   input   | in_valid, in_ready, data_byte, start_of_sound | in
//   result  | out_valid, out_ready, sample_out, last_in_run | out
//   config  | cfg_we, cfg_data (sample_format)            | in
//
// ADPCM data bytes pass twice (one pass per nibble, since the result
// register takes one sample a cycle unless out_ready stalls it); every
// other byte passes once. A sample is loaded from the held item into the
// result register when it can take one; the second ADPCM sample follows.
// Reset sets format 0, predictor 128, step 0 and a pending header.
// A stalled result register holds the item in the input register.
module voice_sample_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              start_of_sound,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] sample_out,
  output logic              last_in_run
);

  logic [1:0] sample_format;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_start;
  logic       nib_phase;

  vsd_pkg::step_req_t req;
  vsd_pkg::step_res_t res;

  assign req.go     = in_full && (!out_valid || out_ready);
  assign req.second = nib_phase;
  assign in_ready   = !in_full || (req.go && res.done);

  vsd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fmt     (sample_format),
    .byte_in (in_byte),
    .start   (in_start),
    .req     (req),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= vsd_pkg::FMT_U8;
    end else if (cfg_we) begin
      sample_format <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      nib_phase <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (req.go && res.done) begin
        in_full <= 1'b0;
      end
      if (req.go) begin
        nib_phase <= !res.done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte  <= data_byte;
      in_start <= start_of_sound;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.go && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go && res.emit) begin
      sample_out  <= $signed(res.sample);
      last_in_run <= res.last;
    end
  end

`ifndef SYNTHESIS
  a_phase_needs_item: assert property (@(posedge clk) disable iff (rst)
    nib_phase |-> in_full)
    else $error("nibble phase set with no item held");
  a_first_half_follows: assert property (@(posedge clk) disable iff (rst)
    req.go && !res.done |=> nib_phase && in_full)
    else $error("second nibble pass lost");
  a_second_half_ends: assert property (@(posedge clk) disable iff (rst)
    nib_phase && req.go |-> res.done && res.emit && res.last)
    else $error("second nibble pass did not finish the item");
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    req.go && res.emit |=> out_valid)
    else $error("sample not loaded into result register");
`endif

endmodule

// ===== dv/voice_sample_decoder_tb.sv =====
// Self-checking testbench for voice_sample_decoder: directed and random byte streams.
module tb;

  localparam int STALL_LIMIT = 1000;

  typedef struct {
    logic signed [7:0] sample;
    logic              last;
  } sample_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_data = vsd_pkg::FMT_U8;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        data_byte = 8'h00;
  logic              start_of_sound = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [7:0] sample_out;
  logic              last_in_run;

  // decoder state as the testbench sees it
  logic [1:0] cur_format = vsd_pkg::FMT_U8;
  int         pred_level = 128;
  int         step_level = 0;
  bit         header_due = 1'b1;
  bit         high_byte_next = 1'b0;

  sample_t expected_samples[$];
  int      errors = 0;
  int      bytes_sent = 0;
  int      samples_checked = 0;
  int      idle_cycles = 0;
  bit      calm = 1'b0;

  voice_sample_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_of_sound(start_of_sound),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .last_in_run   (last_in_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one nibble through the scale/adjust tables; tables rebuilt from their row pattern
  function automatic logic signed [7:0] adpcm_nibble(logic [3:0] nib);
    int idx;
    int grp;
    int mag;
    int scl;
    int adj;
    idx = clamp(int'(nib) + step_level, 0, 63);
    grp = idx >> 4;
    mag = ((idx & 7) << grp) + ((grp > 0) ? (1 << (grp - 1)) : 0);
    scl = (idx & 8) ? -mag : mag;
    if ((idx & 7) == 0 && grp > 0) adj = -16;
    else if ((idx & 7) >= 5 && grp < 3) adj = 16;
    else adj = 0;
    step_level = clamp(step_level + adj, 0, 48);
    pred_level = clamp(pred_level + scl, 0, 255);
    return 8'(pred_level - 128);
  endfunction

  function automatic void push_sample(logic signed [7:0] s, logic last);
    sample_t e;
    e.sample = s;
    e.last = last;
    expected_samples.push_back(e);
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic sos);
    logic signed [7:0] s;
    if (sos) begin
      header_due = 1'b1;
      high_byte_next = 1'b0;
    end
    case (cur_format)
      vsd_pkg::FMT_U8: push_sample(b - 8'd128, 1'b1);
      vsd_pkg::FMT_S8: push_sample(b, 1'b1);
      vsd_pkg::FMT_W16: begin
        if (!high_byte_next) begin
          high_byte_next = 1'b1;
        end else begin
          high_byte_next = 1'b0;
          push_sample(b, 1'b1);
        end
      end
      default: begin
        if (header_due) begin
          pred_level = int'(b);
          step_level = 0;
          header_due = 1'b0;
        end else begin
          s = adpcm_nibble(b[7:4]);
          push_sample(s, 1'b0);
          s = adpcm_nibble(b[3:0]);
          push_sample(s, 1'b1);
        end
      end
    endcase
  endfunction

  // returns at the edge where the item is accepted, valid still high
  task automatic send_byte(logic [7:0] b, logic sos);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_of_sound <= sos;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    decode_byte(b, sos);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  // header bytes and low bytes give no sample, so allow the pipeline to settle too
  task automatic set_format(logic [1:0] f);
    hold_until_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= f;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_format = f;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner [5] = '{8'h77, 8'hFF, 8'h88, 8'h08, 8'h00};
    if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 4)];
    return 8'($urandom);
  endfunction

  task automatic test_reset_format();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_signed();
    set_format(vsd_pkg::FMT_S8);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_word16();
    set_format(vsd_pkg::FMT_W16);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);  // restart mid-word: this is a low byte again
    send_byte(8'h7F, 1'b0);
  endtask

  task automatic test_adpcm_clamps();
    set_format(vsd_pkg::FMT_ADPCM);
    send_byte(8'h00, 1'b0);  // header pending since reset
    send_byte(8'h88, 1'b0);  // nibbles of 8 add nothing, predictor stays at zero
    repeat (3) send_byte(8'h77, 1'b0);
    send_byte(8'hFF, 1'b0);  // top of the index range
    send_byte(8'hF0, 1'b1);
    send_byte(8'h77, 1'b0);  // pushes past 255
    send_byte(8'h08, 1'b0);
  endtask

  task automatic test_start_across_formats();
    set_format(vsd_pkg::FMT_U8);
    send_byte(8'h10, 1'b1);
    set_format(vsd_pkg::FMT_ADPCM);
    send_byte(8'h40, 1'b0);  // header again after the restart seen in U8
    send_byte(8'h3C, 1'b0);
    set_format(vsd_pkg::FMT_W16);
    send_byte(8'h01, 1'b0);
    set_format(vsd_pkg::FMT_S8);
    send_byte(8'h02, 1'b0);
    set_format(vsd_pkg::FMT_W16);
    send_byte(8'h03, 1'b0);  // word phase kept across formats
  endtask

  task automatic run_phase(logic [1:0] f, int n_bytes);
    int k;
    int run_len;
    set_format(f);
    k = 0;
    while (k < n_bytes) begin
      if (f == vsd_pkg::FMT_ADPCM && $urandom_range(0, 9) != 0) begin
        send_byte(8'($urandom), $urandom_range(0, 7) != 0);
        k++;
        run_len = $urandom_range(1, 30);
        repeat (run_len) begin
          send_byte(pick_byte(), $urandom_range(0, 32) == 0);
          k++;
        end
      end else begin
        send_byte(pick_byte(), $urandom_range(0, 19) == 0);
        k++;
      end
      if (!calm && $urandom_range(0, 15) == 0) hold_until_drained();
    end
  endtask

  task automatic test_random_mix();
    logic [1:0] f;
    run_phase(vsd_pkg::FMT_ADPCM, 60);
    run_phase(vsd_pkg::FMT_U8, 20);
    while (bytes_sent < 1150) begin
      f = $urandom_range(0, 1) ? vsd_pkg::FMT_ADPCM : 2'($urandom_range(0, 3));
      run_phase(f, $urandom_range(10, 80));
    end
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    run_phase(vsd_pkg::FMT_ADPCM, 100);
    run_phase(vsd_pkg::FMT_W16, 50);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_samples
    sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected sample: sample_out %0d last_in_run %0b", sample_out, last_in_run);
        errors++;
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (sample_out !== want.sample) begin
          $error("sample_out: expected %0d, got %0d", want.sample, sample_out);
          errors++;
        end
        if (last_in_run !== want.last) begin
          $error("last_in_run: expected %0b, got %0b", want.last, last_in_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d cycles with no item moving", idle_cycles);
      $display("voice_sample_decoder test failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_format();
    test_signed();
    test_word16();
    test_adpcm_clamps();
    test_start_across_formats();
    test_random_mix();
    test_steady_stream();
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $error("%0d samples never arrived", expected_samples.size());
      errors++;
    end
    $display("%0d bytes sent, %0d samples checked over all four formats,", bytes_sent,
             samples_checked);
    $display("with restarts, clamps, format changes and random stalls on both sides");
    if (errors == 0) begin
      $display("voice_sample_decoder test passed");
    end else begin
      $display("voice_sample_decoder test failed");
    end
    $finish;
  end

endmodule
